// ----- src/luhn_ckr_pkg.sv -----
// shared types, codes and small digit functions for the luhn checker
// no dependencies; imported by every module of the block
package luhn_ckr_pkg;

  typedef enum logic [1:0] {
    BRAND_UNKNOWN = 2'd0,
    BRAND_AMEX    = 2'd1,
    BRAND_VISA    = 2'd2,
    BRAND_MC      = 2'd3
  } brand_t;

  typedef enum logic [1:0] {
    STATUS_VALID      = 2'd0,
    STATUS_BAD_FORMAT = 2'd1,
    STATUS_BAD_SUM    = 2'd2
  } status_t;

  localparam int LEN_AMEX       = 15;
  localparam int LEN_VISA_SHORT = 13;
  localparam int LEN_STD        = 16;
  localparam int RADIX          = 10;

  localparam logic [3:0] PFX_AMEX    = 4'd3;
  localparam logic [3:0] PFX_AMEX_A  = 4'd4;
  localparam logic [3:0] PFX_AMEX_B  = 4'd7;
  localparam logic [3:0] PFX_VISA    = 4'd4;
  localparam logic [3:0] PFX_MC      = 4'd5;
  localparam logic [3:0] PFX_MC_LO   = 4'd1;
  localparam logic [3:0] PFX_MC_HI   = 4'd5;

  // everything the classifier needs once the final digit is folded in
  typedef struct packed {
    logic [3:0] first_digit;
    logic [3:0] second_digit;
    logic       len_13;
    logic       len_15;
    logic       len_16;
    logic       sum_zero;
  } luhn_tally_t;

  // tens plus units of twice the digit, digits above nine included
  function automatic logic [4:0] doubled_value(input logic [3:0] d);
    logic [4:0] v;
    case (d)
      4'd0:    v = 5'd0;
      4'd1:    v = 5'd2;
      4'd2:    v = 5'd4;
      4'd3:    v = 5'd6;
      4'd4:    v = 5'd8;
      4'd5:    v = 5'd1;
      4'd6:    v = 5'd3;
      4'd7:    v = 5'd5;
      4'd8:    v = 5'd7;
      4'd9:    v = 5'd9;
      4'd10:   v = 5'd2;
      4'd11:   v = 5'd4;
      4'd12:   v = 5'd6;
      4'd13:   v = 5'd8;
      4'd14:   v = 5'd10;
      4'd15:   v = 5'd3;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // reduce a value below thirty to its units digit
  function automatic logic [3:0] mod10_small(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'(2 * RADIX)) begin
      r = v - 5'(2 * RADIX);
    end else if (v >= 5'(RADIX)) begin
      r = v - 5'(RADIX);
    end else begin
      r = v;
    end
    return r[3:0];
  endfunction

endpackage

// ----- src/luhn_ckr_acc.sv -----
// running state for one card number: count, prefix digits, two luhn sums
// depends on luhn_ckr_pkg
module luhn_ckr_acc
  import luhn_ckr_pkg::*;
#(
  parameter int MAX_DIGITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd,
  input  logic [3:0]  digit,
  input  logic        last,
  output luhn_tally_t tally,
  output logic [4:0]  digit_count
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       first_r, first_nxt;
  logic [3:0]       second_r, second_nxt;
  logic [3:0]       sum_even_r, sum_even_nxt;
  logic [3:0]       sum_odd_r, sum_odd_nxt;
  logic [4:0]       dbl;
  logic [4:0]       plain;
  logic [3:0]       sum_sel;

  always_comb begin
    dbl   = doubled_value(digit);
    plain = {1'b0, digit};

    first_nxt  = (count_r == '0) ? digit : first_r;
    second_nxt = (count_r == CNT_W'(1)) ? digit : second_r;

    // even position from the left: the even-doubling sum doubles it
    if (!count_r[0]) begin
      sum_even_nxt = mod10_small({1'b0, sum_even_r} + dbl);
      sum_odd_nxt  = mod10_small({1'b0, sum_odd_r} + plain);
    end else begin
      sum_even_nxt = mod10_small({1'b0, sum_even_r} + plain);
      sum_odd_nxt  = mod10_small({1'b0, sum_odd_r} + dbl);
    end

    count_nxt = (count_r < CNT_W'(MAX_DIGITS)) ? count_r + CNT_W'(1) : count_r;

    // even length doubles the leftmost digit
    sum_sel = count_nxt[0] ? sum_odd_nxt : sum_even_nxt;

    tally.first_digit  = first_nxt;
    tally.second_digit = second_nxt;
    tally.len_13       = (count_nxt == CNT_W'(LEN_VISA_SHORT));
    tally.len_15       = (count_nxt == CNT_W'(LEN_AMEX));
    tally.len_16       = (count_nxt == CNT_W'(LEN_STD));
    tally.sum_zero     = (sum_sel == 4'd0);
    digit_count        = count_nxt[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      first_r    <= '0;
      second_r   <= '0;
      sum_even_r <= '0;
      sum_odd_r  <= '0;
    end else if (upd) begin
      if (last) begin
        count_r    <= '0;
        first_r    <= '0;
        second_r   <= '0;
        sum_even_r <= '0;
        sum_odd_r  <= '0;
      end else begin
        count_r    <= count_nxt;
        first_r    <= first_nxt;
        second_r   <= second_nxt;
        sum_even_r <= sum_even_nxt;
        sum_odd_r  <= sum_odd_nxt;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond saturation limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && last) |=> (count_r == '0 && sum_even_r == 4'd0 && sum_odd_r == 4'd0))
    else $error("state not cleared after final digit");

  a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (first_r == 4'd0 && second_r == 4'd0))
    else $error("prefix digits held with no digits counted");

endmodule

// ----- src/luhn_ckr_classify.sv -----
// brand and status decode from the folded prefix, length and checksum
// depends on luhn_ckr_pkg
module luhn_ckr_classify
  import luhn_ckr_pkg::*;
(
  input  luhn_tally_t tally,
  output brand_t      brand,
  output status_t     status
);

  logic len_ok;

  always_comb begin
    brand  = BRAND_UNKNOWN;
    len_ok = 1'b0;
    if (tally.first_digit == PFX_AMEX &&
        (tally.second_digit == PFX_AMEX_A || tally.second_digit == PFX_AMEX_B)) begin
      brand  = BRAND_AMEX;
      len_ok = tally.len_15;
    end else if (tally.first_digit == PFX_VISA) begin
      brand  = BRAND_VISA;
      len_ok = tally.len_13 || tally.len_16;
    end else if (tally.first_digit == PFX_MC &&
                 tally.second_digit inside {[PFX_MC_LO:PFX_MC_HI]}) begin
      brand  = BRAND_MC;
      len_ok = tally.len_16;
    end

    if (brand == BRAND_UNKNOWN || !len_ok) begin
      status = STATUS_BAD_FORMAT;
    end else if (!tally.sum_zero) begin
      status = STATUS_BAD_SUM;
    end else begin
      status = STATUS_VALID;
    end
  end

endmodule

// ----- src/card_number_luhn_checker_unit.sv -----
// top level of the card number luhn checker: input register, accumulator,
// classifier and result register; depends on luhn_ckr_pkg, luhn_ckr_acc,
// luhn_ckr_classify
//
//   channel   ports                                      direction
//   input     in_valid, in_stall, in_digit, in_last      digit requests in
//   result    out_valid, out_stall, out_brand,           one request per
//             out_status, out_digit_count                card number out
//
// one digit request per cycle, sustained, while no final digit is held back; the final digit is
// taken into the input register, and the result register loads from it once the
// result register is free, which raises out_valid
// reset is synchronous, active low, and clears all counts and sums
// digits without the last flag keep flowing while a result waits
// a final digit waits in the input register until the result register is free
module card_number_luhn_checker_unit
  import luhn_ckr_pkg::*;
#(
  parameter int MAX_DIGITS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_digit,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_brand,
  output logic [1:0] out_status,
  output logic [4:0] out_digit_count
);

  // input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [3:0] s1_digit_r;
  logic       s1_last_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_brand_r;
  logic [1:0] out_status_r;
  logic [4:0] out_count_r;

  logic        in_take;
  logic        out_free;
  logic        s1_move;
  logic        res_load;
  luhn_tally_t tally;
  logic [4:0]  count_fin;
  brand_t      brand;
  status_t     status;

  // result register can take a new request this cycle
  assign out_free = !out_valid_r || !out_stall;
  // plain digits always advance; a final digit needs a free result slot
  assign s1_move  = s1_valid_r && (!s1_last_r || out_free);
  assign res_load = s1_move && s1_last_r;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  luhn_ckr_acc #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (s1_move),
    .digit       (s1_digit_r),
    .last        (s1_last_r),
    .tally       (tally),
    .digit_count (count_fin)
  );

  luhn_ckr_classify u_classify (
    .tally  (tally),
    .brand  (brand),
    .status (status)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_digit_r <= in_digit;
      s1_last_r  <= in_last;
    end
    if (res_load) begin
      out_brand_r  <= brand;
      out_status_r <= status;
      out_count_r  <= count_fin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_brand       = out_brand_r;
  assign out_status      = out_status_r;
  assign out_digit_count = out_count_r;

  // the input side only backs up behind a final digit and a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked final digit");

  // a fresh result only ever comes from a final digit moving on
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_load))
    else $error("result appeared without a final digit");

  // a valid status always comes with a known brand
  a_valid_has_brand: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_VALID) |-> (out_brand_r != BRAND_UNKNOWN))
    else $error("valid status with unknown brand");

endmodule
